FILE: hdl/sector_buffer_tag_table_assert.svh
// assertion macros used by the checker
`ifndef SECTOR_BUFFER_TAG_TABLE_ASSERT_SVH
`define SECTOR_BUFFER_TAG_TABLE_ASSERT_SVH

// same-cycle implication
`define SBTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sbtt_pkg.sv
`timescale 1ns / 1ps
package sbtt_pkg;

  localparam int DEV_W   = 8;
  localparam int SEC_W   = 32;
  localparam int IDX_W   = 4;
  localparam int COUNT_W = 8;
  localparam int STAT_W  = 3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int QDEPTH  = 2;

  typedef enum logic [1:0] {
    OP_ACQUIRE,
    OP_RELEASE,
    OP_BAD_INDEX
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT,
    ST_MISS,
    ST_FULL,
    ST_IN_USE,
    ST_FREED,
    ST_BAD
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_COMMIT
  } bk_state_t;

  typedef struct packed {
    op_t              op;
    logic [DEV_W-1:0] device_number;
    logic [SEC_W-1:0] sector_number;
    logic [IDX_W-1:0] slot_index;
    logic             dirty_flag;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

FILE: hdl/sbtt_front.sv
`timescale 1ns / 1ps
module sbtt_front #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [sbtt_pkg::DEV_W-1:0]  in_device_number,
  input  logic [sbtt_pkg::SEC_W-1:0]  in_sector_number,
  input  logic [sbtt_pkg::IDX_W-1:0]  in_slot_index,
  input  logic                        in_dirty_flag,
  input  logic                        pop,
  output sbtt_pkg::q_head_t           head
);

  localparam int PW = $clog2(sbtt_pkg::QDEPTH);
  localparam int CW = $clog2(sbtt_pkg::QDEPTH + 1);

  sbtt_pkg::item_t q_r [sbtt_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  sbtt_pkg::item_t cls_item;
  logic            push;

  // classify the incoming transaction
  always_comb begin
    cls_item.device_number = in_device_number;
    cls_item.sector_number = in_sector_number;
    cls_item.slot_index    = in_slot_index;
    cls_item.dirty_flag    = in_dirty_flag;
    if (!in_mode) begin
      cls_item.op = sbtt_pkg::OP_ACQUIRE;
    end else if (int'(in_slot_index) < SLOTS) begin
      cls_item.op = sbtt_pkg::OP_RELEASE;
    end else begin
      cls_item.op = sbtt_pkg::OP_BAD_INDEX;
    end
  end

  assign in_ready = (cnt_r != CW'(sbtt_pkg::QDEPTH));
  assign push     = in_valid && in_ready;

  always_comb begin
    wr_ptr_nxt = push ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = CW'(cnt_r + CW'(push) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls_item;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

endmodule

FILE: hdl/sbtt_back.sv
`timescale 1ns / 1ps
module sbtt_back #(
  parameter int SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sbtt_pkg::q_head_t            head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbtt_pkg::IDX_W-1:0]   out_slot_out,
  output logic [sbtt_pkg::STAT_W-1:0]  out_status,
  output logic                         out_read_request,
  output logic                         out_write_back
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // tag table
  logic [SLOTS-1:0]                 valid_r;
  logic [sbtt_pkg::COUNT_W-1:0]     count_r [SLOTS];
  logic [sbtt_pkg::DEV_W-1:0]       dev_r   [SLOTS];
  logic [sbtt_pkg::SEC_W-1:0]       sec_r   [SLOTS];

  // lookup stage
  logic [SLOTS-1:0] hit_vec_r, hit_vec_nxt;
  logic [SLOTS-1:0] free_vec_r, free_vec_nxt;
  logic [SLOTS-1:0] sel_vec_r, sel_vec_nxt;
  logic [SLOTS-1:0] last_vec_r, last_vec_nxt;
  sbtt_pkg::item_t  item_r;

  sbtt_pkg::bk_state_t state_r, state_nxt;
  logic                load;
  logic                fire;

  // commit stage
  logic [SW-1:0]    hit_idx, free_idx;
  logic             hit_any, free_any, freed;
  logic [SLOTS-1:0] inc_vec, alloc_vec;
  logic [sbtt_pkg::IDX_W-1:0]  res_slot;
  sbtt_pkg::status_t           res_status;
  logic                        res_rd, res_wb;

  logic                        out_valid_r, out_valid_nxt;
  logic [sbtt_pkg::IDX_W-1:0]  out_slot_r;
  logic [sbtt_pkg::STAT_W-1:0] out_status_r;
  logic                        out_rd_r, out_wb_r;

  function automatic logic [SW-1:0] lowest(input logic [SLOTS-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = SW'(i);
      end
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec_nxt[i]  = valid_r[i] && (dev_r[i] == head.item.device_number) &&
                        (sec_r[i] == head.item.sector_number);
      free_vec_nxt[i] = !valid_r[i];
      sel_vec_nxt[i]  = valid_r[i] && (head.item.op == sbtt_pkg::OP_RELEASE) &&
                        (int'(head.item.slot_index) == i);
      last_vec_nxt[i] = (count_r[i] <= sbtt_pkg::COUNT_W'(1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    fire      = 1'b0;
    unique case (state_r)
      sbtt_pkg::BK_IDLE: begin
        if (head.valid) begin
          load      = 1'b1;
          state_nxt = sbtt_pkg::BK_COMMIT;
        end
      end
      sbtt_pkg::BK_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          fire      = 1'b1;
          state_nxt = sbtt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sbtt_pkg::BK_IDLE;
    endcase
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbtt_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit_vec_r  <= hit_vec_nxt;
      free_vec_r <= free_vec_nxt;
      sel_vec_r  <= sel_vec_nxt;
      last_vec_r <= last_vec_nxt;
      item_r     <= head.item;
    end
  end

  always_comb begin
    hit_idx  = lowest(hit_vec_r);
    free_idx = lowest(free_vec_r);
    hit_any  = |hit_vec_r;
    free_any = |free_vec_r;
    freed    = |(sel_vec_r & last_vec_r);
    for (int i = 0; i < SLOTS; i++) begin
      inc_vec[i]   = (item_r.op == sbtt_pkg::OP_ACQUIRE) && hit_any &&
                     (hit_idx == SW'(i));
      alloc_vec[i] = (item_r.op == sbtt_pkg::OP_ACQUIRE) && !hit_any && free_any &&
                     (free_idx == SW'(i));
    end
    res_slot   = item_r.slot_index;
    res_status = sbtt_pkg::ST_BAD;
    res_rd     = 1'b0;
    res_wb     = 1'b0;
    unique case (item_r.op)
      sbtt_pkg::OP_ACQUIRE: begin
        priority if (hit_any) begin
          res_slot   = sbtt_pkg::IDX_W'(hit_idx);
          res_status = sbtt_pkg::ST_HIT;
        end else if (free_any) begin
          res_slot   = sbtt_pkg::IDX_W'(free_idx);
          res_status = sbtt_pkg::ST_MISS;
          res_rd     = 1'b1;
        end else begin
          res_slot   = '0;
          res_status = sbtt_pkg::ST_FULL;
        end
      end
      sbtt_pkg::OP_RELEASE: begin
        if (|sel_vec_r) begin
          res_status = freed ? sbtt_pkg::ST_FREED : sbtt_pkg::ST_IN_USE;
          res_wb     = item_r.dirty_flag;
        end
      end
      default: begin
        res_status = sbtt_pkg::ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        count_r[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < SLOTS; i++) begin
        priority if (inc_vec[i]) begin
          if (count_r[i] != sbtt_pkg::COUNT_MAX) begin
            count_r[i] <= sbtt_pkg::COUNT_W'(count_r[i] + 1'b1);
          end
        end else if (alloc_vec[i]) begin
          valid_r[i] <= 1'b1;
          count_r[i] <= sbtt_pkg::COUNT_W'(1);
        end else if (sel_vec_r[i]) begin
          if (count_r[i] != '0) begin
            count_r[i] <= sbtt_pkg::COUNT_W'(count_r[i] - 1'b1);
          end
          if (last_vec_r[i]) begin
            valid_r[i] <= 1'b0;
          end
        end
      end
    end
  end

  // tags carry no reset, only valid slots are compared
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (alloc_vec[i]) begin
          dev_r[i] <= item_r.device_number;
          sec_r[i] <= item_r.sector_number;
        end
      end
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_slot_r   <= res_slot;
      out_status_r <= res_status;
      out_rd_r     <= res_rd;
      out_wb_r     <= res_wb;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_out     = out_slot_r;
  assign out_status       = out_status_r;
  assign out_read_request = out_rd_r;
  assign out_write_back   = out_wb_r;

endmodule

FILE: hdl/sector_buffer_tag_table.sv
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// in_      input      in_valid / in_ready  mode, device_number, sector_number, slot_index,
//                                          dirty_flag
// out_     output     out_valid/out_ready  slot_out, status, read_request, write_back
//
// two steps per transaction: one registers the tag match and free vectors of all slots,
// one priority-encodes them, updates the table and loads the output register
// a two-entry queue between the front and the table lets input keep arriving while the
// table waits on out_ready; in_ready drops only when the queue is full
// synchronous active-low reset clears the valid marks, use counts, queue and output valid
module sector_buffer_tag_table #(
  parameter int SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [sbtt_pkg::DEV_W-1:0]   in_device_number,
  input  logic [sbtt_pkg::SEC_W-1:0]   in_sector_number,
  input  logic [sbtt_pkg::IDX_W-1:0]   in_slot_index,
  input  logic                         in_dirty_flag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbtt_pkg::IDX_W-1:0]   out_slot_out,
  output logic [sbtt_pkg::STAT_W-1:0]  out_status,
  output logic                         out_read_request,
  output logic                         out_write_back
);

  sbtt_pkg::q_head_t head;
  logic              pop;

  sbtt_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_device_number (in_device_number),
    .in_sector_number (in_sector_number),
    .in_slot_index    (in_slot_index),
    .in_dirty_flag    (in_dirty_flag),
    .pop              (pop),
    .head             (head)
  );

  sbtt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_out     (out_slot_out),
    .out_status       (out_status),
    .out_read_request (out_read_request),
    .out_write_back   (out_write_back)
  );

endmodule

FILE: hdl/sbtt_checker.sv
`timescale 1ns / 1ps
`include "sector_buffer_tag_table_assert.svh"
module sbtt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sbtt_pkg::IDX_W-1:0]   out_slot_out,
  input logic [sbtt_pkg::STAT_W-1:0]  out_status,
  input logic                         out_read_request,
  input logic                         out_write_back
);

  // a device read goes with a fresh allocation and nothing else
  `SBTT_ASSERT_NOW(a_read_on_miss, out_valid,
    out_read_request == (out_status == sbtt_pkg::ST_MISS), "read request without miss")

  // write-back only from a good release
  `SBTT_ASSERT_NOW(a_wb_on_release, out_valid && out_write_back,
    out_status == sbtt_pkg::ST_IN_USE || out_status == sbtt_pkg::ST_FREED,
    "write-back outside a release")

  // a full table reports slot zero
  `SBTT_ASSERT_NOW(a_full_slot, out_valid && out_status == sbtt_pkg::ST_FULL,
    out_slot_out == '0, "full status with nonzero slot")

  // a stalled result holds
  `SBTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_slot_out) && $stable(out_status), "stalled result changed")

endmodule

bind sector_buffer_tag_table sbtt_checker u_sbtt_checker (.*);
